FILE: rtl/rwlt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwlt_pkg
// Shared types and constants of the reader/writer lock table.
// ----------------------------------------------------------------------------
package rwlt_pkg;

  localparam int unsigned MODE_W      = 2;
  localparam int unsigned IN_KEY_W    = 32;
  localparam int unsigned STATUS_W    = 3;
  localparam int unsigned HOLD_W      = 16;
  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 24;
  localparam int unsigned KEY_EXT_W   = 64;

  localparam logic signed [HOLD_W-1:0] HOLD_MAX    = 16'sd32767;
  localparam logic signed [HOLD_W-1:0] WRITER_HELD = -16'sd1;
  localparam logic signed [HOLD_W-1:0] HOLD_NONE   = 16'sd0;
  localparam logic signed [HOLD_W-1:0] HOLD_ONE    = 16'sd1;

  typedef enum logic [MODE_W-1:0] {
    MODE_OPEN      = 2'd0,
    MODE_CLOSE     = 2'd1,
    MODE_DOWNGRADE = 2'd2,
    MODE_UPGRADE   = 2'd3
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_WRITER    = 3'd1,
    ST_BUSY      = 3'd2,
    ST_FULL      = 3'd3,
    ST_NOT_FREED = 3'd4,
    ST_NO_ENTRY  = 3'd5,
    ST_VIOLATION = 3'd6
  } status_e;

  // controller -> datapath
  typedef struct packed {
    logic load_req;  // latch request, restart scan
    logic scan_en;   // read the entry at the scan index
    logic commit;    // apply table update, load result register
  } rwlt_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_last;
  } rwlt_sts_t;

endpackage

FILE: rtl/rwlt_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwlt_ctrl
// Request sequencer: accept, scan, drain, decide, hand over to result beat.
// ----------------------------------------------------------------------------
module rwlt_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  rwlt_pkg::rwlt_sts_t sts_i,
  output rwlt_pkg::rwlt_cmd_t cmd_o
);
  import rwlt_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_DECIDE
  } state_e;

  state_e state_q;
  logic   out_valid_q;

  assign in_ready_o      = (state_q == S_IDLE);
  assign out_valid_o     = out_valid_q;
  assign cmd_o.load_req  = in_valid_i && (state_q == S_IDLE);
  assign cmd_o.scan_en   = (state_q == S_SCAN);
  assign cmd_o.commit    = (state_q == S_DECIDE) && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.commit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) state_q <= S_SCAN;
        end
        S_SCAN: begin
          if (sts_i.scan_last) state_q <= S_DRAIN;
        end
        S_DRAIN: begin
          state_q <= S_DECIDE;
        end
        S_DECIDE: begin
          if (cmd_o.commit) state_q <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: rtl/rwlt_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwlt_dp
// Lock table storage, sequential lookup and the per-request decision.
// ----------------------------------------------------------------------------
module rwlt_dp #(
  parameter int unsigned TABLE_ENTRIES = 16,
  parameter int unsigned KEY_BITS      = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  rwlt_pkg::rwlt_cmd_t              cmd_i,
  output rwlt_pkg::rwlt_sts_t              sts_o,
  input  logic [rwlt_pkg::MODE_W-1:0]      mode_i,
  input  logic [rwlt_pkg::IN_KEY_W-1:0]    key_i,
  input  logic                             read_only_i,
  input  logic                             swap_in_use_i,
  output logic [rwlt_pkg::STATUS_W-1:0]    status_o,
  output logic signed [rwlt_pkg::HOLD_W-1:0] holders_after_o
);
  import rwlt_pkg::*;

  localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned ENT_W = KEY_BITS + HOLD_W;

  // request
  mode_e               mode_q;
  logic [KEY_BITS-1:0] key_q;
  logic                rd_q;
  logic                swap_q;
  logic [KEY_EXT_W-1:0] key_ext;

  // table: valid bits in flops, key/count in memory
  logic [TABLE_ENTRIES-1:0] valid_q;
  logic [ENT_W-1:0]         mem_q [TABLE_ENTRIES];

  // scan pipeline
  logic [IDX_W-1:0] idx_q;
  logic [ENT_W-1:0] rdata_q;
  logic             chk_en_q;
  logic             chk_valid_q;
  logic [IDX_W-1:0] chk_idx_q;

  // lookup results
  logic                     found_q;
  logic [IDX_W-1:0]         hit_idx_q;
  logic signed [HOLD_W-1:0] hit_h_q;
  logic                     free_q;
  logic [IDX_W-1:0]         free_idx_q;

  // decision
  status_e                  status_d;
  logic signed [HOLD_W-1:0] after_d;
  logic                     wr_en;
  logic [IDX_W-1:0]         wr_idx;
  logic signed [HOLD_W-1:0] new_h;
  logic                     set_v;
  logic                     clr_v;

  // result register
  status_e                  status_q;
  logic signed [HOLD_W-1:0] after_q;

  assign key_ext         = {{(KEY_EXT_W-IN_KEY_W){1'b0}}, key_i};
  assign sts_o.scan_last = (idx_q == IDX_W'(TABLE_ENTRIES - 1));
  assign status_o        = status_q;
  assign holders_after_o = after_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      mode_q <= mode_e'(mode_i);
      key_q  <= key_ext[KEY_BITS-1:0];
      rd_q   <= read_only_i;
      swap_q <= swap_in_use_i;
    end
    if (cmd_i.commit && wr_en) begin
      mem_q[wr_idx] <= {key_q, new_h};
    end
    if (cmd_i.scan_en) begin
      rdata_q     <= mem_q[idx_q];
      chk_valid_q <= valid_q[idx_q];
      chk_idx_q   <= idx_q;
    end
    if (cmd_i.commit) begin
      status_q <= status_d;
      after_q  <= after_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      idx_q      <= '0;
      chk_en_q   <= 1'b0;
      found_q    <= 1'b0;
      free_q     <= 1'b0;
      hit_idx_q  <= '0;
      free_idx_q <= '0;
      hit_h_q    <= HOLD_NONE;
    end else begin
      chk_en_q <= cmd_i.scan_en;
      if (cmd_i.load_req) begin
        idx_q   <= '0;
        found_q <= 1'b0;
        free_q  <= 1'b0;
      end else begin
        if (cmd_i.scan_en) idx_q <= idx_q + 1'b1;
        if (chk_en_q) begin
          // first matching entry wins; lowest free slot kept
          if (chk_valid_q && !found_q && (rdata_q[ENT_W-1:HOLD_W] == key_q)) begin
            found_q   <= 1'b1;
            hit_idx_q <= chk_idx_q;
            hit_h_q   <= rdata_q[HOLD_W-1:0];
          end
          if (!chk_valid_q && !free_q) begin
            free_q     <= 1'b1;
            free_idx_q <= chk_idx_q;
          end
        end
      end
      if (cmd_i.commit) begin
        if (set_v) valid_q[wr_idx]    <= 1'b1;
        if (clr_v) valid_q[hit_idx_q] <= 1'b0;
      end
    end
  end

  always_comb begin
    status_d = ST_OK;
    after_d  = HOLD_NONE;
    wr_en    = 1'b0;
    wr_idx   = hit_idx_q;
    new_h    = hit_h_q;
    set_v    = 1'b0;
    clr_v    = 1'b0;
    case (mode_q)
      MODE_OPEN: begin
        if (found_q) begin
          after_d = hit_h_q;
          if (rd_q) begin
            if (hit_h_q < HOLD_NONE) begin
              status_d = ST_WRITER;
            end else if (hit_h_q >= HOLD_MAX) begin
              status_d = ST_BUSY;
            end else begin
              new_h   = hit_h_q + HOLD_ONE;
              wr_en   = 1'b1;
              after_d = new_h;
            end
          end else begin
            if (hit_h_q != HOLD_NONE) begin
              status_d = ST_BUSY;
            end else begin
              new_h   = WRITER_HELD;
              wr_en   = 1'b1;
              after_d = WRITER_HELD;
            end
          end
        end else if (!free_q) begin
          status_d = ST_FULL;
        end else if (swap_q) begin
          status_d = ST_BUSY;
        end else begin
          wr_idx  = free_idx_q;
          new_h   = rd_q ? HOLD_ONE : WRITER_HELD;
          wr_en   = 1'b1;
          set_v   = 1'b1;
          after_d = new_h;
        end
      end
      MODE_CLOSE: begin
        if (!found_q) begin
          status_d = ST_NOT_FREED;
        end else if (rd_q) begin
          if (hit_h_q <= HOLD_NONE) begin
            status_d = ST_VIOLATION;
            after_d  = hit_h_q;
          end else if (hit_h_q == HOLD_ONE) begin
            clr_v = 1'b1;
          end else begin
            new_h    = hit_h_q - HOLD_ONE;
            wr_en    = 1'b1;
            status_d = ST_NOT_FREED;
            after_d  = new_h;
          end
        end else if (hit_h_q != WRITER_HELD) begin
          status_d = ST_VIOLATION;
          after_d  = hit_h_q;
        end else begin
          clr_v = 1'b1;
        end
      end
      MODE_DOWNGRADE: begin
        if (!found_q) begin
          status_d = ST_NO_ENTRY;
        end else if (hit_h_q != WRITER_HELD) begin
          status_d = ST_VIOLATION;
          after_d  = hit_h_q;
        end else begin
          new_h   = HOLD_ONE;
          wr_en   = 1'b1;
          after_d = HOLD_ONE;
        end
      end
      MODE_UPGRADE: begin
        if (!found_q) begin
          status_d = ST_NO_ENTRY;
        end else if (hit_h_q != HOLD_ONE) begin
          status_d = ST_BUSY;
          after_d  = hit_h_q;
        end else begin
          new_h   = WRITER_HELD;
          wr_en   = 1'b1;
          after_d = WRITER_HELD;
        end
      end
      default: begin
        status_d = ST_OK;
      end
    endcase
  end

endmodule

FILE: rtl/reader_writer_lock_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// reader_writer_lock_table
// Fixed table of keyed reader/writer locks with open, close, downgrade and
// upgrade requests; one status beat per request.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive as beats on the s_axis channel, results leave as beats on
//   the m_axis channel, exactly one result beat per request beat, in order.
//   A request is taken when s_axis_tvalid_i and s_axis_tready_o are both high.
//   The block then walks the table one entry per cycle through a single
//   registered read port: a scan of every entry, a drain step that checks
//   the last entry read, and a decision step that updates the table and
//   loads the result register. A new request is taken only once the previous
//   one has left its decision step; the scan length sets the rate.
//   Lookup takes the first valid entry whose key matches; a new entry goes to
//   the lowest free slot. Keys are compared on their low KEY_BITS bits.
//   The result register frees the input side: the next request is taken and
//   scanned while a result still waits. If the sink stalls, the finished
//   request holds in its decision cycle, table untouched, until the result
//   register empties.
//   Reset (rst_ni low, asynchronous) empties the table at once by clearing the
//   valid bits; key and count storage is not cleared and needs no pass.
// ----------------------------------------------------------------------------
module reader_writer_lock_table #(
  parameter int unsigned TABLE_ENTRIES = 16,
  parameter int unsigned KEY_BITS      = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // request channel
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // [1:0] mode, [33:2] key, [34] read_only, [35] swap_in_use, [39:36] zero
  input  logic [rwlt_pkg::IN_TDATA_W-1:0]     s_axis_tdata_i,
  // result channel
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // [2:0] status, [18:3] holders_after (signed), [23:19] zero
  output logic [rwlt_pkg::OUT_TDATA_W-1:0]    m_axis_tdata_o
);
  import rwlt_pkg::*;

  localparam int unsigned OUT_PAD_W = OUT_TDATA_W - STATUS_W - HOLD_W;

  rwlt_cmd_t                cmd;
  rwlt_sts_t                sts;
  logic [STATUS_W-1:0]      status;
  logic signed [HOLD_W-1:0] holders_after;

  // Sequencer: owns handshakes and the scan / decide schedule
  rwlt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Table storage, lookup and decision
  rwlt_dp #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .KEY_BITS      (KEY_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .mode_i          (s_axis_tdata_i[MODE_W-1:0]),
    .key_i           (s_axis_tdata_i[MODE_W+IN_KEY_W-1:MODE_W]),
    .read_only_i     (s_axis_tdata_i[MODE_W+IN_KEY_W]),
    .swap_in_use_i   (s_axis_tdata_i[MODE_W+IN_KEY_W+1]),
    .status_o        (status),
    .holders_after_o (holders_after)
  );

  assign m_axis_tdata_o = {{OUT_PAD_W{1'b0}}, holders_after, status};

`ifndef SYNTHESIS
  // once a request is taken, no further beat is taken on the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
    else $error("request accepted while previous one still in progress");

  // a result is only loaded when the result register is free or draining
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |-> (!m_axis_tvalid_o || m_axis_tready_i))
    else $error("result register overwritten before it was taken");

  // full table and missing entry always report a zero holder count
  a_zero_holders: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && ((status == ST_FULL) || (status == ST_NO_ENTRY)))
      |-> (holders_after == HOLD_NONE))
    else $error("nonzero holder count with full or no-entry status");

  // status codes above violation are never produced
  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (status != 3'd7))
    else $error("undefined status code on result channel");
`endif

endmodule
